/* rtl/core/nnb_pkg.sv */
// Shared types and constants for the nearest-neighbor blit address mapper.
// Used by every module under rtl/core; depends on nothing.
package nnb_pkg;

  localparam int COORD_W    = 11;
  localparam int PROD_W     = 2 * COORD_W;
  localparam int BASE_W     = 24;
  localparam int ADDR_W     = 25;
  localparam int INDEX_W    = 16;
  localparam int PIX_W      = 8;
  localparam int DIV_STEPS  = COORD_W;
  localparam int DIV_STAGES = DIV_STEPS + 1;
  localparam int PIPE_STAGES = DIV_STAGES + 3;

  typedef enum logic [2:0] {
    REG_DEST_LEFT   = 3'd0,
    REG_DEST_TOP    = 3'd1,
    REG_DEST_WIDTH  = 3'd2,
    REG_DEST_HEIGHT = 3'd3,
    REG_SRC_WIDTH   = 3'd4,
    REG_SRC_HEIGHT  = 3'd5,
    REG_SRC_BASE    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } in_t;

  typedef struct packed {
    logic               write_enable;
    logic [INDEX_W-1:0] dest_index;
    logic [ADDR_W-1:0]  source_address;
  } out_t;

  typedef struct packed {
    logic               write_enable;
    logic [INDEX_W-1:0] dest_index;
  } side_t;

  typedef struct packed {
    logic [COORD_W-1:0] dest_left;
    logic [COORD_W-1:0] dest_top;
    logic [COORD_W-1:0] dest_width;
    logic [COORD_W-1:0] dest_height;
    logic [COORD_W-1:0] src_width;
    logic [COORD_W-1:0] src_height;
    logic [BASE_W-1:0]  src_base;
  } cfg_t;

endpackage

/* rtl/core/nnb_clip.sv */
// First pipeline stage: rectangle and surface window test, axis offsets, surface index.
// Depends on nnb_pkg.
module nnb_clip #(
  parameter int SURFACE_WIDTH  = 240,
  parameter int SURFACE_HEIGHT = 240
) (
  input  logic                        clk,
  input  logic                        ld,
  input  nnb_pkg::in_t                in_i,
  input  nnb_pkg::cfg_t               cfg,
  output nnb_pkg::side_t              side_o,
  output logic [nnb_pkg::COORD_W-1:0] off_x_o,
  output logic [nnb_pkg::COORD_W-1:0] off_y_o
);

  localparam logic [nnb_pkg::COORD_W-1:0] LIM_X   = nnb_pkg::COORD_W'(SURFACE_WIDTH);
  localparam logic [nnb_pkg::COORD_W-1:0] LIM_Y   = nnb_pkg::COORD_W'(SURFACE_HEIGHT);
  localparam logic [nnb_pkg::INDEX_W-1:0] SURF_W  = nnb_pkg::INDEX_W'(SURFACE_WIDTH);

  logic signed [12:0] dx, dy, org_x, org_y, end_x, end_y, off_x, off_y;
  logic               in_x, in_y, sizes_ok;
  nnb_pkg::side_t     side_nxt;
  nnb_pkg::side_t     side_r;
  logic [nnb_pkg::COORD_W-1:0] off_x_r, off_y_r;

  always_comb begin
    dx    = $signed({5'b0, in_i.pixel_x});
    dy    = $signed({5'b0, in_i.pixel_y});
    org_x = $signed({{2{cfg.dest_left[10]}}, cfg.dest_left});
    org_y = $signed({{2{cfg.dest_top[10]}}, cfg.dest_top});
    end_x = org_x + $signed({2'b0, cfg.dest_width});
    end_y = org_y + $signed({2'b0, cfg.dest_height});
    off_x = dx - org_x;
    off_y = dy - org_y;
    in_x  = ({3'b0, in_i.pixel_x} < LIM_X) && (dx >= org_x) && (dx < end_x);
    in_y  = ({3'b0, in_i.pixel_y} < LIM_Y) && (dy >= org_y) && (dy < end_y);
    sizes_ok = (|cfg.dest_width) && (|cfg.dest_height) &&
               (|cfg.src_width) && (|cfg.src_height);
    side_nxt.write_enable = sizes_ok && in_x && in_y;
    side_nxt.dest_index   = {8'b0, in_i.pixel_y} * SURF_W + {8'b0, in_i.pixel_x};
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      side_r  <= side_nxt;
      off_x_r <= off_x[10:0];
      off_y_r <= off_y[10:0];
    end
  end

  assign side_o  = side_r;
  assign off_x_o = off_x_r;
  assign off_y_o = off_y_r;

endmodule

/* rtl/core/nnb_div.sv */
// One axis of the scaler: offset times source size, then a pipelined restoring
// divide by the destination size, one quotient bit per stage. Depends on nnb_pkg.
module nnb_div (
  input  logic                           clk,
  input  logic [nnb_pkg::DIV_STAGES-1:0] ld,
  input  logic [nnb_pkg::COORD_W-1:0]    off_i,
  input  logic [nnb_pkg::COORD_W-1:0]    ssize,
  input  logic [nnb_pkg::COORD_W-1:0]    dsize,
  output logic [nnb_pkg::COORD_W-1:0]    q_o
);

  localparam int W = nnb_pkg::COORD_W;

  logic [nnb_pkg::PROD_W-1:0] prod_r;
  logic [W-1:0] rem_in  [nnb_pkg::DIV_STEPS];
  logic [W-1:0] low_in  [nnb_pkg::DIV_STEPS];
  logic [W-1:0] quo_in  [nnb_pkg::DIV_STEPS];
  logic [W-1:0] rem_nxt [nnb_pkg::DIV_STEPS];
  logic [W-1:0] low_nxt [nnb_pkg::DIV_STEPS];
  logic [W-1:0] quo_nxt [nnb_pkg::DIV_STEPS];
  logic [W-1:0] rem_r   [nnb_pkg::DIV_STEPS];
  logic [W-1:0] low_r   [nnb_pkg::DIV_STEPS];
  logic [W-1:0] quo_r   [nnb_pkg::DIV_STEPS];

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      prod_r <= {{W{1'b0}}, off_i} * {{W{1'b0}}, ssize};
    end
  end

  // The offset is below the destination size, so the quotient fits in W bits
  // and the top half of the product already starts below the divisor.
  genvar k;
  for (k = 0; k < nnb_pkg::DIV_STEPS; k++) begin : g_step
    logic [W:0] trial;
    logic       ge;

    if (k == 0) begin : g_first
      assign rem_in[k] = prod_r[nnb_pkg::PROD_W-1:W];
      assign low_in[k] = prod_r[W-1:0];
      assign quo_in[k] = '0;
    end else begin : g_next
      assign rem_in[k] = rem_r[k-1];
      assign low_in[k] = low_r[k-1];
      assign quo_in[k] = quo_r[k-1];
    end

    always_comb begin
      trial      = {rem_in[k], low_in[k][W-1]};
      ge         = trial >= {1'b0, dsize};
      rem_nxt[k] = ge ? W'(trial - {1'b0, dsize}) : trial[W-1:0];
      low_nxt[k] = {low_in[k][W-2:0], 1'b0};
      quo_nxt[k] = {quo_in[k][W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (ld[k+1]) begin
        rem_r[k] <= rem_nxt[k];
        low_r[k] <= low_nxt[k];
        quo_r[k] <= quo_nxt[k];
      end
    end
  end

  assign q_o = quo_r[nnb_pkg::DIV_STEPS-1];

endmodule

/* rtl/core/nnb_addr.sv */
// Last two pipeline stages: source row times source width, then base plus
// row offset plus column into the output register. Depends on nnb_pkg.
module nnb_addr (
  input  logic                        clk,
  input  logic [1:0]                  ld,
  input  nnb_pkg::side_t              side_i,
  input  logic [nnb_pkg::COORD_W-1:0] sx_i,
  input  logic [nnb_pkg::COORD_W-1:0] sy_i,
  input  logic [nnb_pkg::COORD_W-1:0] src_width,
  input  logic [nnb_pkg::BASE_W-1:0]  src_base,
  output nnb_pkg::out_t               out_o
);

  localparam int W = nnb_pkg::COORD_W;

  logic [nnb_pkg::PROD_W-1:0] row_r;
  logic [W-1:0]               sx_r;
  nnb_pkg::side_t             side_r;
  nnb_pkg::out_t              out_nxt;
  nnb_pkg::out_t              out_r;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      row_r  <= {{W{1'b0}}, sy_i} * {{W{1'b0}}, src_width};
      sx_r   <= sx_i;
      side_r <= side_i;
    end
  end

  // A disabled pixel reports zero in both index fields.
  always_comb begin
    out_nxt.write_enable = side_r.write_enable;
    if (side_r.write_enable) begin
      out_nxt.dest_index     = side_r.dest_index;
      out_nxt.source_address = {1'b0, src_base} + nnb_pkg::ADDR_W'(row_r) +
                               nnb_pkg::ADDR_W'(sx_r);
    end else begin
      out_nxt.dest_index     = '0;
      out_nxt.source_address = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      out_r <= out_nxt;
    end
  end

  assign out_o = out_r;

endmodule

/* rtl/core/nearest_neighbor_blit_address_map.sv */
// Nearest-neighbor blit address mapper. Takes one destination pixel coordinate per clock
// while in_ready is high and returns one result per coordinate, in order. The pipeline
// holds a clip stage, a multiply stage, an 11-stage restoring divider (one quotient bit
// per stage), a row multiply and a final add into the output register. Every stage
// holds its own valid bit, so stalls at the output fill empty stages before in_ready
// drops. Configuration registers are written through the cfg port, which never stalls,
// and must be written only while no pixel is in flight.
module nearest_neighbor_blit_address_map #(
  parameter int SURFACE_WIDTH  = 240,
  parameter int SURFACE_HEIGHT = 240
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  nnb_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output nnb_pkg::out_t              out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [2:0]                 cfg_index,
  input  logic [nnb_pkg::BASE_W-1:0] cfg_data
);

  localparam int NS = nnb_pkg::PIPE_STAGES;
  localparam int DS = nnb_pkg::DIV_STAGES;

  nnb_pkg::cfg_t  cfg_r;
  logic [NS-1:0]  v_r;
  logic [NS:0]    rdy;
  nnb_pkg::side_t side_a;
  nnb_pkg::side_t side_r [DS];
  logic [nnb_pkg::COORD_W-1:0] off_x, off_y, sx, sy;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        nnb_pkg::REG_DEST_LEFT:   cfg_r.dest_left   <= cfg_data[10:0];
        nnb_pkg::REG_DEST_TOP:    cfg_r.dest_top    <= cfg_data[10:0];
        nnb_pkg::REG_DEST_WIDTH:  cfg_r.dest_width  <= cfg_data[10:0];
        nnb_pkg::REG_DEST_HEIGHT: cfg_r.dest_height <= cfg_data[10:0];
        nnb_pkg::REG_SRC_WIDTH:   cfg_r.src_width   <= cfg_data[10:0];
        nnb_pkg::REG_SRC_HEIGHT:  cfg_r.src_height  <= cfg_data[10:0];
        nnb_pkg::REG_SRC_BASE:    cfg_r.src_base    <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or its content moves on in the same cycle.
  always_comb begin
    rdy[NS] = out_ready;
    for (int i = NS - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];

  nnb_clip #(
    .SURFACE_WIDTH (SURFACE_WIDTH),
    .SURFACE_HEIGHT(SURFACE_HEIGHT)
  ) u_clip (
    .clk    (clk),
    .ld     (rdy[0]),
    .in_i   (in_data),
    .cfg    (cfg_r),
    .side_o (side_a),
    .off_x_o(off_x),
    .off_y_o(off_y)
  );

  nnb_div u_div_x (
    .clk  (clk),
    .ld   (rdy[DS:1]),
    .off_i(off_x),
    .ssize(cfg_r.src_width),
    .dsize(cfg_r.dest_width),
    .q_o  (sx)
  );

  nnb_div u_div_y (
    .clk  (clk),
    .ld   (rdy[DS:1]),
    .off_i(off_y),
    .ssize(cfg_r.src_height),
    .dsize(cfg_r.dest_height),
    .q_o  (sy)
  );

  // Enable and surface index ride alongside the divider stages.
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      side_r[0] <= side_a;
    end
    for (int k = 1; k < DS; k++) begin
      if (rdy[k+1]) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  nnb_addr u_addr (
    .clk      (clk),
    .ld       (rdy[NS-1:NS-2]),
    .side_i   (side_r[DS-1]),
    .sx_i     (sx),
    .sy_i     (sy),
    .src_width(cfg_r.src_width),
    .src_base (cfg_r.src_base),
    .out_o    (out_data)
  );

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("accepted pixel did not enter the first stage");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r) && !out_ready |-> !in_ready)
    else $error("input accepted while every stage is full and stalled");

  a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.write_enable |->
      out_data.dest_index == '0 && out_data.source_address == '0)
    else $error("disabled pixel carries a nonzero index");

endmodule

/* sim/tb_nearest_neighbor_blit_address_map.sv */
// Self-checking testbench for the nearest-neighbor blit address mapper.
// Holds a scoreboard class that predicts each pixel's mapping from its own copy of the
// registers; depends only on nnb_pkg and the nearest_neighbor_blit_address_map RTL.
module tb_nearest_neighbor_blit_address_map;

  localparam int SURF_W = 240;
  localparam int SURF_H = 240;
  localparam int DRAIN_CYCLES = 2 * nnb_pkg::PIPE_STAGES + 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 12;
  localparam int PIXELS_PER_PHASE = 125;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  class blit_map_scoreboard;
    nnb_pkg::cfg_t regs;
    nnb_pkg::out_t expected_maps[$];
    int unsigned mismatches;

    function new();
      regs = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [nnb_pkg::BASE_W-1:0] data);
      case (idx)
        nnb_pkg::REG_DEST_LEFT:   regs.dest_left = data[nnb_pkg::COORD_W-1:0];
        nnb_pkg::REG_DEST_TOP:    regs.dest_top = data[nnb_pkg::COORD_W-1:0];
        nnb_pkg::REG_DEST_WIDTH:  regs.dest_width = data[nnb_pkg::COORD_W-1:0];
        nnb_pkg::REG_DEST_HEIGHT: regs.dest_height = data[nnb_pkg::COORD_W-1:0];
        nnb_pkg::REG_SRC_WIDTH:   regs.src_width = data[nnb_pkg::COORD_W-1:0];
        nnb_pkg::REG_SRC_HEIGHT:  regs.src_height = data[nnb_pkg::COORD_W-1:0];
        nnb_pkg::REG_SRC_BASE:    regs.src_base = data;
        default: ;
      endcase
    endfunction

    // Scales one axis; a miss means the coordinate is off the surface or the span.
    function bit axis_hit(longint d, logic [nnb_pkg::COORD_W-1:0] origin,
                          logic [nnb_pkg::COORD_W-1:0] dsize,
                          logic [nnb_pkg::COORD_W-1:0] ssize,
                          longint limit, output longint src);
      longint org, ds, ss, q;
      org = $signed(origin);
      ds = dsize;
      ss = ssize;
      src = 0;
      if (d >= limit || d < org || d >= org + ds) return 0;
      q = ((d - org) * ss) / ds;
      if (q > ss - 1) q = ss - 1;
      src = q;
      return 1;
    endfunction

    function nnb_pkg::out_t map_pixel(nnb_pkg::in_t p);
      nnb_pkg::out_t r;
      longint sx, sy, idx, addr;
      bit hit;
      r = '0;
      sx = 0;
      sy = 0;
      hit = regs.dest_width != 0 && regs.dest_height != 0 &&
            regs.src_width != 0 && regs.src_height != 0;
      if (hit) hit = axis_hit(p.pixel_x, regs.dest_left, regs.dest_width,
                              regs.src_width, SURF_W, sx);
      if (hit) hit = axis_hit(p.pixel_y, regs.dest_top, regs.dest_height,
                              regs.src_height, SURF_H, sy);
      if (hit) begin
        idx = longint'(p.pixel_y) * SURF_W + longint'(p.pixel_x);
        addr = longint'(regs.src_base) + sy * longint'(regs.src_width) + sx;
        r.write_enable = 1'b1;
        r.dest_index = idx[nnb_pkg::INDEX_W-1:0];
        r.source_address = addr[nnb_pkg::ADDR_W-1:0];
      end
      return r;
    endfunction

    function void note_pixel(nnb_pkg::in_t p);
      expected_maps = {expected_maps, map_pixel(p)};
    endfunction

    function void check_result(nnb_pkg::out_t got);
      nnb_pkg::out_t want;
      if (expected_maps.size() == 0) begin
        $error("result transfer with no pixel outstanding: %h", got);
        mismatches++;
        return;
      end
      want = expected_maps.pop_front();
      if (got.write_enable !== want.write_enable) begin
        $error("write_enable: expected %0d, actual %0d", want.write_enable, got.write_enable);
        mismatches++;
      end
      if (got.dest_index !== want.dest_index) begin
        $error("dest_index: expected %0d, actual %0d", want.dest_index, got.dest_index);
        mismatches++;
      end
      if (got.source_address !== want.source_address) begin
        $error("source_address: expected %0d, actual %0d",
               want.source_address, got.source_address);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_maps.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  nnb_pkg::in_t in_data;
  logic out_valid;
  logic out_ready;
  nnb_pkg::out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [nnb_pkg::BASE_W-1:0] cfg_data;
  bit no_idle;
  int cycle_count;

  blit_map_scoreboard sb = new();

  nearest_neighbor_blit_address_map #(
    .SURFACE_WIDTH(SURF_W),
    .SURFACE_HEIGHT(SURF_H)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic nnb_pkg::cfg_t make_cfg(int left, int top, int dw, int dh, int sw,
                                             int sh, int base);
    nnb_pkg::cfg_t c;
    c.dest_left = left[nnb_pkg::COORD_W-1:0];
    c.dest_top = top[nnb_pkg::COORD_W-1:0];
    c.dest_width = dw[nnb_pkg::COORD_W-1:0];
    c.dest_height = dh[nnb_pkg::COORD_W-1:0];
    c.src_width = sw[nnb_pkg::COORD_W-1:0];
    c.src_height = sh[nnb_pkg::COORD_W-1:0];
    c.src_base = base[nnb_pkg::BASE_W-1:0];
    return c;
  endfunction

  // Mostly lands inside the visible part of the span, otherwise anywhere in the field.
  function automatic int pick_coord(logic [nnb_pkg::COORD_W-1:0] origin,
                                    logic [nnb_pkg::COORD_W-1:0] size, int limit);
    int org, lo, hi;
    org = $signed(origin);
    lo = (org < 0) ? 0 : org;
    hi = org + int'(size) - 1;
    if (hi > limit - 1) hi = limit - 1;
    if ($urandom_range(9) < 8 && lo <= hi) return $urandom_range(hi, lo);
    return $urandom_range(255);
  endfunction

  // All driving tasks are entered and left at a falling edge.
  task automatic send_pixel(input int x, input int y);
    nnb_pkg::in_t p;
    p.pixel_x = x[nnb_pkg::PIX_W-1:0];
    p.pixel_y = y[nnb_pkg::PIX_W-1:0];
    while (!no_idle && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_pixel(p);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [nnb_pkg::BASE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
    @(negedge clk);
  endtask

  // Upper data bits are random so that the narrow registers must ignore them.
  task automatic load_config(input nnb_pkg::cfg_t c);
    logic [nnb_pkg::BASE_W-1:0] hi;
    wait_idle();
    hi = nnb_pkg::BASE_W'($urandom);
    write_reg(REG_UNUSED, nnb_pkg::BASE_W'($urandom));
    write_reg(nnb_pkg::REG_DEST_LEFT, {hi[nnb_pkg::BASE_W-1:nnb_pkg::COORD_W], c.dest_left});
    write_reg(nnb_pkg::REG_DEST_TOP, {hi[nnb_pkg::BASE_W-1:nnb_pkg::COORD_W], c.dest_top});
    write_reg(nnb_pkg::REG_DEST_WIDTH,
              {hi[nnb_pkg::BASE_W-1:nnb_pkg::COORD_W], c.dest_width});
    write_reg(nnb_pkg::REG_DEST_HEIGHT,
              {hi[nnb_pkg::BASE_W-1:nnb_pkg::COORD_W], c.dest_height});
    write_reg(nnb_pkg::REG_SRC_WIDTH,
              {hi[nnb_pkg::BASE_W-1:nnb_pkg::COORD_W], c.src_width});
    write_reg(nnb_pkg::REG_SRC_HEIGHT,
              {hi[nnb_pkg::BASE_W-1:nnb_pkg::COORD_W], c.src_height});
    write_reg(nnb_pkg::REG_SRC_BASE, c.src_base);
    cfg_valid <= 1'b0;
  endtask

  initial begin : result_sink
    int hold_left;
    int results_seen;
    hold_left = 0;
    results_seen = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= no_idle || $urandom_range(99) >= 7;
      end
      @(posedge clk);
      if (out_valid && out_ready) begin
        sb.check_result(out_data);
        results_seen++;
        // One long back-pressure episode while the sender keeps streaming.
        if (results_seen == 200) hold_left = 150;
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_nearest_neighbor_blit_address_map: FAIL");
    $finish;
  end

  initial begin : stimulus
    nnb_pkg::cfg_t c;
    int dw, dh;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    no_idle = 1'b0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Registers still at reset: every size is zero, so nothing is written.
    send_pixel(0, 0);
    send_pixel(255, 255);

    // Rectangle edges, one step outside each edge, and pixels beyond the surface.
    load_config(make_cfg(10, 20, 100, 50, 37, 1023, 24'hFFFFFF));
    send_pixel(10, 20);
    send_pixel(109, 69);
    send_pixel(9, 20);
    send_pixel(110, 20);
    send_pixel(10, 19);
    send_pixel(10, 70);
    send_pixel(60, 45);
    send_pixel(240, 30);
    send_pixel(30, 240);

    // Most negative origin with the widest register values.
    load_config(make_cfg(-1024, -1024, 2047, 2047, 2047, 2047, 24'hFFFFFF));
    send_pixel(0, 0);
    send_pixel(239, 239);
    send_pixel(255, 0);
    send_pixel(0, 255);

    // A single-pixel rectangle in the last surface corner.
    load_config(make_cfg(239, 239, 1, 1, 1, 1, 0));
    send_pixel(239, 239);
    send_pixel(238, 239);
    send_pixel(239, 238);

    // Most positive origin puts the whole rectangle off the surface.
    load_config(make_cfg(1023, 0, 1024, 1024, 1024, 1024, 5));
    send_pixel(0, 0);

    // Each size register at zero on its own disables the write.
    load_config(make_cfg(0, 0, 0, 64, 64, 64, 1));
    send_pixel(5, 5);
    load_config(make_cfg(0, 0, 64, 0, 64, 64, 1));
    send_pixel(5, 5);
    load_config(make_cfg(0, 0, 64, 64, 0, 64, 1));
    send_pixel(5, 5);
    load_config(make_cfg(0, 0, 64, 64, 64, 0, 1));
    send_pixel(5, 5);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph % 4 == 3) begin
        // Anything the register widths allow, sometimes with one size cleared.
        c = make_cfg($urandom_range(2047), $urandom_range(2047), $urandom_range(2047),
                     $urandom_range(2047), $urandom_range(2047), $urandom_range(2047),
                     $urandom_range(24'hFFFFFF));
        if ($urandom_range(2) == 0) begin
          case ($urandom_range(3))
            0: c.dest_width = '0;
            1: c.dest_height = '0;
            2: c.src_width = '0;
            default: c.src_height = '0;
          endcase
        end
      end else begin
        dw = $urandom_range(300, 1);
        dh = $urandom_range(300, 1);
        c = make_cfg(int'($urandom_range(239 + dw)) - dw, int'($urandom_range(239 + dh)) - dh,
                     dw, dh,
                     $urandom_range(1) ? $urandom_range(16, 1) : $urandom_range(1024, 1),
                     $urandom_range(1) ? $urandom_range(16, 1) : $urandom_range(1024, 1),
                     $urandom_range(24'hFFFFFF));
      end
      load_config(c);
      no_idle = (ph == 2);
      for (int i = 0; i < PIXELS_PER_PHASE; i++) begin
        send_pixel(pick_coord(c.dest_left, c.dest_width, SURF_W),
                   pick_coord(c.dest_top, c.dest_height, SURF_H));
      end
      no_idle = 1'b0;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_nearest_neighbor_blit_address_map: PASS");
    end else begin
      $display("tb_nearest_neighbor_blit_address_map: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/nnb_pkg.sv
rtl/core/nnb_clip.sv
rtl/core/nnb_div.sv
rtl/core/nnb_addr.sv
rtl/core/nearest_neighbor_blit_address_map.sv
sim/tb_nearest_neighbor_blit_address_map.sv
